[rtl/core/matrix_inverse_gauss_jordan_macros.svh]
// Assertion macros shared by the checker of the Gauss-Jordan matrix inverse.
// Depends on nothing; included by the checker file.
`ifndef MATRIX_INVERSE_GAUSS_JORDAN_MACROS_SVH
`define MATRIX_INVERSE_GAUSS_JORDAN_MACROS_SVH
`define MIG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MIG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/core/mig_pkg.sv]
// Shared types and constants of the Gauss-Jordan matrix inverse.
// Depends on nothing; used by the controller, datapath and top level.
package mig_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_INIT    = 3'd1,
        OP_FACTOR  = 3'd2,
        OP_UPDATE  = 3'd3,
        OP_RECIP   = 3'd4,
        OP_SCALE   = 3'd5
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] k;
        logic [2:0] j;
        logic [2:0] i;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic zero_pivot;
    } status_t;

endpackage

[rtl/core/matrix_inverse_gauss_jordan.sv]
// Top level of the 4x4 Gauss-Jordan matrix inverse in signed fixed point.
// Depends on mig_pkg, mig_ctrl, mig_datapath and mig_div.
// One matrix of DIM*DIM words is taken, then inverted, then DIM*DIM words
// are given out; no new word is taken until the last result is taken. Each
// row factor and reciprocal waits for the serial divider, and a zero pivot
// ends the inversion early.
module matrix_inverse_gauss_jordan #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] element_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] inverse_value,
    output logic               last_element,
    output logic               singular,
    output logic               overflowed
);

    localparam int AW = $clog2(DIM * DIM);

    mig_pkg::cmd_t      cmd;
    mig_pkg::status_t   status;
    logic               load_en;
    logic [AW-1:0]      load_addr;
    logic [AW-1:0]      rd_addr;
    logic signed [31:0] rd_data;

    mig_ctrl #(.DIM(DIM)) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .last_element (last_element),
        .singular     (singular),
        .load_en      (load_en),
        .load_addr    (load_addr),
        .rd_addr      (rd_addr),
        .cmd          (cmd),
        .status       (status)
    );

    mig_datapath #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_en   (load_en),
        .load_addr (load_addr),
        .load_data (element_value),
        .cmd       (cmd),
        .status    (status),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .ovf       (overflowed)
    );

    assign inverse_value = singular ? 32'sd0 : rd_data;

endmodule

[rtl/core/mig_div.sv]
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing but its ports.
module mig_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic                    done,
    output logic signed [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   r_reg;
    logic [DEN_W-1:0] d_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DEN_W+1:0] trial;
    logic [DEN_W+1:0] shifted;

    always_comb
    begin
        shifted = {r_reg, q_reg[NUM_W-1]};
        trial   = shifted - {2'b00, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num[NUM_W-1] ? (~num + 1'b1) : num;
            d_reg   <= den[DEN_W-1] ? (~den + 1'b1) : den;
            r_reg   <= '0;
            neg_reg <= num[NUM_W-1] ^ den[DEN_W-1];
        end
        else if (run_reg)
        begin
            if (!trial[DEN_W+1])
            begin
                r_reg <= trial[DEN_W:0];
                q_reg <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted[DEN_W:0];
                q_reg <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

[rtl/core/mig_datapath.sv]
// Datapath of the matrix inverse: both matrices, two multipliers, the divider.
// Depends on mig_pkg and mig_div.
module mig_datapath #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load_en,
    input  logic [$clog2(DIM*DIM)-1:0] load_addr,
    input  logic signed [31:0]        load_data,
    input  mig_pkg::cmd_t             cmd,
    output mig_pkg::status_t          status,
    input  logic [$clog2(DIM*DIM)-1:0] rd_addr,
    output logic signed [31:0]        rd_data,
    output logic                      ovf
);

    localparam int CELLS = DIM * DIM;
    localparam int AW    = $clog2(CELLS);
    localparam logic signed [63:0] MAX32 = 64'sd2147483647;
    localparam logic signed [63:0] MIN32 = -64'sd2147483648;

    logic signed [31:0] work_mem [CELLS];
    logic signed [31:0] inv_mem  [CELLS];
    logic signed [31:0] s_reg;
    logic               ovf_reg;
    logic [1:0]         ph_reg;
    logic               div_start;
    logic               div_done;
    logic signed [63:0] div_num;
    logic signed [31:0] div_den;
    logic signed [63:0] div_q;
    logic               div_busy_reg;
    logic signed [63:0] pw_reg;
    logic signed [63:0] pi_reg;
    logic signed [31:0] xw_reg;
    logic signed [31:0] xi_reg;
    logic [AW-1:0]      a_jk;
    logic [AW-1:0]      a_kk;
    logic [AW-1:0]      a_ji;
    logic [AW-1:0]      a_ki;
    logic signed [63:0] sum_w;
    logic signed [63:0] sum_i;

    function automatic logic signed [63:0] sat_val(input logic signed [63:0] v);
        if (v > MAX32)
            return MAX32;
        if (v < MIN32)
            return MIN32;
        return v;
    endfunction

    function automatic logic is_sat(input logic signed [63:0] v);
        return (v > MAX32) || (v < MIN32);
    endfunction

    assign a_jk = AW'(cmd.j * DIM + cmd.k);
    assign a_kk = AW'(cmd.k * DIM + cmd.k);
    assign a_ji = AW'(cmd.j * DIM + cmd.i);
    assign a_ki = AW'(cmd.k * DIM + cmd.i);

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = work_mem[a_kk];
        if (cmd.op == mig_pkg::OP_FACTOR && !div_busy_reg)
        begin
            div_start = 1'b1;
            div_num   = -($signed(64'(work_mem[a_jk])) <<< FRAC_BITS);
        end
        else if (cmd.op == mig_pkg::OP_RECIP && !div_busy_reg)
        begin
            div_den   = work_mem[AW'(cmd.j * DIM + cmd.j)];
            div_start = (div_den != 32'sd0);
            div_num   = 64'sd1 <<< (2 * FRAC_BITS);
        end
        sum_w = $signed(64'(xw_reg)) + (pw_reg >>> FRAC_BITS);
        sum_i = $signed(64'(xi_reg)) + (pi_reg >>> FRAC_BITS);
    end

    mig_div #(.NUM_W(64), .DEN_W(32)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg      <= 1'b0;
            ph_reg       <= '0;
            div_busy_reg <= 1'b0;
        end
        else
        begin
            if (div_start)
                div_busy_reg <= 1'b1;
            if (div_done)
            begin
                div_busy_reg <= 1'b0;
                ph_reg       <= '0;
                if (is_sat(div_q))
                    ovf_reg <= 1'b1;
            end
            if (cmd.op == mig_pkg::OP_INIT)
                ovf_reg <= 1'b0;
            if (cmd.op == mig_pkg::OP_UPDATE || cmd.op == mig_pkg::OP_SCALE)
            begin
                ph_reg <= (ph_reg == 2'd2) ? 2'd0 : ph_reg + 2'd1;
                if (ph_reg == 2'd2)
                begin
                    if (cmd.op == mig_pkg::OP_UPDATE && (is_sat(sum_w) || is_sat(sum_i)))
                        ovf_reg <= 1'b1;
                    if (cmd.op == mig_pkg::OP_SCALE && is_sat(pi_reg >>> FRAC_BITS))
                        ovf_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
            work_mem[load_addr] <= load_data;
        if (div_done)
            s_reg <= 32'(sat_val(div_q));
        case (cmd.op)
            mig_pkg::OP_INIT:
            begin
                for (int n = 0; n < CELLS; n++)
                    inv_mem[n] <= (n / DIM == n % DIM) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
            end
            mig_pkg::OP_UPDATE:
            begin
                if (ph_reg == 2'd0)
                begin
                    xw_reg <= work_mem[a_ki];
                    xi_reg <= inv_mem[a_ki];
                end
                else if (ph_reg == 2'd1)
                begin
                    pw_reg <= $signed(64'(s_reg)) * $signed(64'(xw_reg));
                    pi_reg <= $signed(64'(s_reg)) * $signed(64'(xi_reg));
                    xw_reg <= work_mem[a_ji];
                    xi_reg <= inv_mem[a_ji];
                end
                else
                begin
                    work_mem[a_ji] <= 32'(sat_val(sum_w));
                    inv_mem[a_ji]  <= 32'(sat_val(sum_i));
                end
            end
            mig_pkg::OP_SCALE:
            begin
                if (ph_reg == 2'd0)
                    xi_reg <= inv_mem[a_ji];
                else if (ph_reg == 2'd1)
                    pi_reg <= $signed(64'(s_reg)) * $signed(64'(xi_reg));
                else
                    inv_mem[a_ji] <= 32'(sat_val(pi_reg >>> FRAC_BITS));
            end
            default:
            begin
            end
        endcase
    end

    assign status.busy       = div_busy_reg && !div_done;
    assign status.zero_pivot = (cmd.op == mig_pkg::OP_RECIP)
                             ? (work_mem[AW'(cmd.j * DIM + cmd.j)] == 32'sd0)
                             : (work_mem[a_kk] == 32'sd0);
    assign rd_data = inv_mem[rd_addr];
    assign ovf     = ovf_reg;

endmodule

[rtl/core/mig_ctrl.sv]
// Controller of the matrix inverse: loading, elimination sequence, output.
// Depends on mig_pkg; drives mig_datapath by command and status.
module mig_ctrl #(
    parameter int DIM = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       last_element,
    output logic                       singular,
    output logic                       load_en,
    output logic [$clog2(DIM*DIM)-1:0] load_addr,
    output logic [$clog2(DIM*DIM)-1:0] rd_addr,
    output mig_pkg::cmd_t              cmd,
    input  mig_pkg::status_t           status
);

    localparam int CELLS = DIM * DIM;
    localparam int AW    = $clog2(CELLS);
    localparam logic [2:0] LAST = 3'(DIM - 1);

    typedef enum logic [2:0] {
        S_LOAD, S_INIT, S_CHECK, S_FACTOR, S_UPDATE, S_RECIP, S_SCALE, S_OUT
    } state_t;

    state_t     state_reg;
    logic [AW-1:0] cnt_reg;
    logic [2:0] k_reg, j_reg, i_reg;
    logic [1:0] ph_reg;
    logic       sing_reg;
    logic       wait_reg;

    assign in_ready  = (state_reg == S_LOAD);
    assign load_en   = in_valid && in_ready;
    assign load_addr = cnt_reg;
    assign rd_addr   = cnt_reg;
    assign out_valid = (state_reg == S_OUT);
    assign last_element = (cnt_reg == AW'(CELLS - 1));
    assign singular  = sing_reg;

    always_comb
    begin
        cmd.op = mig_pkg::OP_NONE;
        cmd.k  = k_reg;
        cmd.j  = j_reg;
        cmd.i  = i_reg;
        unique case (state_reg)
            S_INIT:   cmd.op = mig_pkg::OP_INIT;
            S_FACTOR: cmd.op = wait_reg ? mig_pkg::OP_NONE : mig_pkg::OP_FACTOR;
            S_UPDATE: cmd.op = mig_pkg::OP_UPDATE;
            S_RECIP:  cmd.op = wait_reg ? mig_pkg::OP_NONE : mig_pkg::OP_RECIP;
            S_SCALE:  cmd.op = mig_pkg::OP_SCALE;
            default:  cmd.op = mig_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            k_reg     <= '0;
            j_reg     <= '0;
            i_reg     <= '0;
            ph_reg    <= '0;
            sing_reg  <= 1'b0;
            wait_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (load_en)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == AW'(CELLS - 1))
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_INIT;
                        end
                    end
                end
                S_INIT:
                begin
                    sing_reg  <= 1'b0;
                    k_reg     <= '0;
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (status.zero_pivot)
                    begin
                        sing_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        j_reg     <= (k_reg == 3'd0) ? 3'd1 : 3'd0;
                        wait_reg  <= 1'b0;
                        state_reg <= S_FACTOR;
                    end
                end
                S_FACTOR:
                begin
                    wait_reg <= 1'b1;
                    if (wait_reg && !status.busy)
                    begin
                        i_reg     <= '0;
                        ph_reg    <= '0;
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    ph_reg <= (ph_reg == 2'd2) ? 2'd0 : ph_reg + 2'd1;
                    if (ph_reg == 2'd2)
                    begin
                        i_reg <= i_reg + 3'd1;
                        if (i_reg == LAST)
                        begin
                            wait_reg <= 1'b0;
                            if (j_reg == LAST || (j_reg + 3'd1 == k_reg && k_reg == LAST))
                            begin
                                if (k_reg == LAST)
                                begin
                                    j_reg     <= '0;
                                    state_reg <= S_RECIP;
                                end
                                else
                                begin
                                    k_reg     <= k_reg + 3'd1;
                                    state_reg <= S_CHECK;
                                end
                            end
                            else
                            begin
                                j_reg     <= (j_reg + 3'd1 == k_reg) ? j_reg + 3'd2
                                                                     : j_reg + 3'd1;
                                state_reg <= S_FACTOR;
                            end
                        end
                    end
                end
                S_RECIP:
                begin
                    wait_reg <= 1'b1;
                    if (!wait_reg && status.zero_pivot)
                    begin
                        sing_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else if (wait_reg && !status.busy)
                    begin
                        i_reg     <= '0;
                        ph_reg    <= '0;
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    ph_reg <= (ph_reg == 2'd2) ? 2'd0 : ph_reg + 2'd1;
                    if (ph_reg == 2'd2)
                    begin
                        i_reg <= i_reg + 3'd1;
                        if (i_reg == LAST)
                        begin
                            wait_reg <= 1'b0;
                            if (j_reg == LAST)
                                state_reg <= S_OUT;
                            else
                            begin
                                j_reg     <= j_reg + 3'd1;
                                state_reg <= S_RECIP;
                            end
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == AW'(CELLS - 1))
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_LOAD;
                        end
                    end
                end
                default:
                    state_reg <= S_LOAD;
            endcase
        end
    end

endmodule

[rtl/core/mig_checker.sv]
// Port checker of the matrix inverse, bound to the top level.
// Depends on the assertion macro header.
`include "matrix_inverse_gauss_jordan_macros.svh"
module mig_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] inverse_value,
    input logic        singular
);

    `MIG_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    `MIG_ASSERT_IMPL(a_sing_zero, clk, rst_n, out_valid && singular, inverse_value == 32'd0)
    `MIG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

bind matrix_inverse_gauss_jordan mig_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .inverse_value (inverse_value),
    .singular      (singular)
);
